// ----- src/frc_pkg.sv -----
// Shared types and constants for the FIFO-replacement frame cache.
package frc_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 31;
   localparam int PAY_W        = 32;

   typedef enum logic [1:0] {
      OP_GET   = 2'd0,
      OP_PUT   = 2'd1,
      OP_HAS   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Per-transaction commands broadcast to every cell
   typedef struct packed {
      logic look;     // latch key match for the incoming transaction
      logic upd;      // put hit: overwrite payload in the matching cell
      logic shift;    // put miss on a full cache: drop oldest, take neighbor
      logic append;   // put miss with room: write the cell at the fill index
   } cell_ctl_type;

endpackage

// ----- src/fifo_replacement_frame_cache_core.sv -----
// Top level of the FIFO-replacement frame cache: control, fill count, cell row.
//
//  channel | dir | tdata                          | tuser
//  req     | in  | frame_key[30:0], payload_in    | op[1:0]
//  rsp     | out | payload_out[31:0]              | found[0]
//
// Each transaction runs as accept then resolve: the accept edge latches a key
// match in every cell, and the resolve edge resolves the hit, updates the cell
// row and loads the result register. A new request is taken in the cycle after resolve.
// Reset clears only the fill count and control; entry contents stay as is.
// A stalled result holds the resolve step until the result register frees.
module fifo_replacement_frame_cache_core
   import frc_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [30:0] frame_key, [62:31] payload_in, [63] zero
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] payload_out
   output logic [0:0]  rsp_tuser    // [0] found
);

   localparam int FILL_W = $clog2(CAPACITY + 1);

   typedef enum logic {ST_IDLE, ST_RESOLVE} state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [PAY_W-1:0]  rsp_pay_ff, rsp_pay_in;

   cell_ctl_type      ctl;
   logic              accept;
   logic              fire;
   logic              full;
   logic              any_hit;
   logic [PAY_W-1:0]  hit_pay_all;
   logic              is_put;

   logic [KEY_W-1:0]  cell_key [CAPACITY];
   logic [PAY_W-1:0]  cell_pay [CAPACITY];
   logic [PAY_W-1:0]  cell_hpay [CAPACITY];
   logic [CAPACITY-1:0] hit_vec;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp_tready);
   assign full       = fill_ff == FILL_W'(CAPACITY);
   assign is_put     = (op_ff == OP_PUT);

   always_comb begin
      any_hit     = 1'b0;
      hit_pay_all = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_hit     = any_hit | hit_vec[i];
         hit_pay_all = hit_pay_all | cell_hpay[i];
      end
   end

   always_comb begin
      ctl.look   = accept;
      ctl.upd    = fire && is_put && any_hit;
      ctl.shift  = fire && is_put && !any_hit && full;
      ctl.append = fire && is_put && !any_hit && !full;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [KEY_W-1:0] nbr_key;
         logic [PAY_W-1:0] nbr_pay;
         if (g == CAPACITY - 1) begin : g_tail
            assign nbr_key = key_ff;
            assign nbr_pay = pay_ff;
         end else begin : g_link
            assign nbr_key = cell_key[g+1];
            assign nbr_pay = cell_pay[g+1];
         end
         frc_cell #(
            .INDEX  (g),
            .FILL_W (FILL_W)
         ) u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .fill     (fill_ff),
            .look_key (req_tdata[KEY_W-1:0]),
            .new_key  (key_ff),
            .new_pay  (pay_ff),
            .nbr_key  (nbr_key),
            .nbr_pay  (nbr_pay),
            .key_out  (cell_key[g]),
            .pay_out  (cell_pay[g]),
            .hit      (hit_vec[g]),
            .hit_pay  (cell_hpay[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      rsp_pay_in   = rsp_pay_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_tuser);
               key_in   = req_tdata[KEY_W-1:0];
               pay_in   = req_tdata[KEY_W+PAY_W-1:KEY_W];
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               found_in     = any_hit && (op_ff != OP_CLEAR);
               rsp_pay_in   = (op_ff == OP_GET && any_hit) ? hit_pay_all : '0;
               if (op_ff == OP_CLEAR) begin
                  fill_in = '0;
               end else if (ctl.append) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      pay_ff     <= pay_in;
      found_ff   <= found_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pay_ff;
   assign rsp_tuser[0] = found_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count above capacity");

   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(hit_vec))
      else $error("key matched in more than one cell");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.append |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("append did not grow fill count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (fire && op_ff == OP_CLEAR) |=> fill_ff == '0)
      else $error("clear left entries");

   a_full_stays: assert property (@(posedge clock) disable iff (reset)
      ctl.shift |=> full)
      else $error("eviction changed fill count");
`endif

endmodule

// ----- src/frc_cell.sv -----
// One cache entry: key, payload, registered match flag, link to its neighbor.
module frc_cell
   import frc_pkg::*;
#(
   parameter int INDEX  = 0,
   parameter int FILL_W = 7
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [FILL_W-1:0] fill,
   input  logic [KEY_W-1:0]  look_key,
   input  logic [KEY_W-1:0]  new_key,
   input  logic [PAY_W-1:0]  new_pay,
   input  logic [KEY_W-1:0]  nbr_key,
   input  logic [PAY_W-1:0]  nbr_pay,
   output logic [KEY_W-1:0]  key_out,
   output logic [PAY_W-1:0]  pay_out,
   output logic              hit,
   output logic [PAY_W-1:0]  hit_pay
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic             hit_ff, hit_in;
   logic             occupied;
   logic             at_fill;

   assign occupied = FILL_W'(INDEX) < fill;
   assign at_fill  = FILL_W'(INDEX) == fill;

   always_comb begin
      key_in = key_ff;
      pay_in = pay_ff;
      hit_in = hit_ff;
      if (ctl.look) begin
         hit_in = occupied && (key_ff == look_key);
      end
      if (ctl.shift) begin
         key_in = nbr_key;
         pay_in = nbr_pay;
      end else if (ctl.append && at_fill) begin
         key_in = new_key;
         pay_in = new_pay;
      end else if (ctl.upd && hit_ff) begin
         pay_in = new_pay;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
      hit_ff <= hit_in;
   end

   assign key_out = key_ff;
   assign pay_out = pay_ff;
   assign hit     = hit_ff;
   assign hit_pay = hit_ff ? pay_ff : '0;

endmodule
